// ===== design/svm_dual_loss_gradient_unit_macros.svh =====
// ----------------------------------------------------------------------------
// SVM dual gradient unit - assertion macros
// Clocked assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SVM_DUAL_LOSS_GRADIENT_UNIT_MACROS_SVH
`define SVM_DUAL_LOSS_GRADIENT_UNIT_MACROS_SVH

// Check on every clock edge once reset is released.
`define SDLG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define SDLG_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/sdlg_pkg.sv =====
// ----------------------------------------------------------------------------
// SVM dual gradient package
// Sizes, codes, control structs and address helper shared by the unit.
// ----------------------------------------------------------------------------
package sdlg_pkg;

    localparam int MAX_SIZE = 32;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int CNT_W    = 6;
    localparam int MAT_AW   = $clog2(MAX_SIZE * MAX_SIZE);
    localparam int DATA_W   = 32;
    localparam int RES_W    = 64;
    localparam int ACC_W    = 72;
    localparam int SUM_W    = DATA_W + CNT_W;

    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [CNT_W-1:0] SIZE_LIMIT   = CNT_W'(MAX_SIZE);
    localparam logic [CNT_W-1:0] ACTIVE_RESET = CNT_W'(32);

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_ALPHA  = 1'b1;
    localparam logic KIND_GRAD = 1'b0;
    localparam logic KIND_LOSS = 1'b1;

    // one operand pair sent into the multiply pipeline
    typedef struct packed {
        logic valid;
        logic loss;
        logic zero_b;
        logic first_row;
    } mac_issue_t;

    typedef struct packed {
        logic       start;
        logic       row_clear;
        mac_issue_t issue;
        logic       grad_latch;
        logic       loss_latch;
    } mac_ctrl_t;

    typedef struct packed {
        logic             load_grad;
        logic             load_loss;
        logic [CNT_W-1:0] index;
    } emit_t;

    function automatic logic [MAT_AW-1:0] mat_addr(input logic [CNT_W-1:0] r,
                                                   input logic [CNT_W-1:0] c);
        mat_addr = MAT_AW'(r) * MAT_AW'(MAX_SIZE) + MAT_AW'(c);
    endfunction

endpackage

// ===== design/sdlg_store.sv =====
// ----------------------------------------------------------------------------
// SVM dual gradient storage
// Matrix and alpha memories, one write and one registered read port each.
// ----------------------------------------------------------------------------
module sdlg_store (
    input  logic                              clk,
    input  logic                              mat_we,
    input  logic [sdlg_pkg::MAT_AW-1:0]       mat_waddr,
    input  logic signed [sdlg_pkg::DATA_W-1:0] mat_wdata,
    input  logic [sdlg_pkg::MAT_AW-1:0]       mat_raddr,
    output logic signed [sdlg_pkg::DATA_W-1:0] mat_rdata,
    input  logic                              alpha_we,
    input  logic [sdlg_pkg::IDX_W-1:0]        alpha_waddr,
    input  logic signed [sdlg_pkg::DATA_W-1:0] alpha_wdata,
    input  logic [sdlg_pkg::IDX_W-1:0]        alpha_raddr,
    output logic signed [sdlg_pkg::DATA_W-1:0] alpha_rdata
);

    logic signed [sdlg_pkg::DATA_W-1:0] mat_mem [sdlg_pkg::MAX_SIZE * sdlg_pkg::MAX_SIZE];
    logic signed [sdlg_pkg::DATA_W-1:0] alpha_mem [sdlg_pkg::MAX_SIZE];
    logic signed [sdlg_pkg::DATA_W-1:0] mat_rdata_reg;
    logic signed [sdlg_pkg::DATA_W-1:0] alpha_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_waddr] <= mat_wdata;
        end
        mat_rdata_reg <= mat_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (alpha_we)
        begin
            alpha_mem[alpha_waddr] <= alpha_wdata;
        end
        alpha_rdata_reg <= alpha_mem[alpha_raddr];
    end

    assign mat_rdata   = mat_rdata_reg;
    assign alpha_rdata = alpha_rdata_reg;

endmodule

// ===== design/sdlg_mac.sv =====
// ----------------------------------------------------------------------------
// SVM dual gradient multiply-accumulate unit
// Shared multiplier with row, loss and alpha-sum accumulators and saturation.
// ----------------------------------------------------------------------------
module sdlg_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sdlg_pkg::mac_ctrl_t                ctrl,
    input  logic signed [sdlg_pkg::DATA_W-1:0] mat_rdata,
    input  logic signed [sdlg_pkg::DATA_W-1:0] alpha_rdata,
    output logic signed [sdlg_pkg::DATA_W-1:0] grad,
    output logic signed [sdlg_pkg::RES_W-1:0]  loss
);

    localparam logic signed [sdlg_pkg::ACC_W-1:0] GRAD_BIAS = sdlg_pkg::ACC_W'(65536);
    localparam logic signed [sdlg_pkg::DATA_W-1:0] S32_MAX = {1'b0, {(sdlg_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [sdlg_pkg::DATA_W-1:0] S32_MIN = {1'b1, {(sdlg_pkg::DATA_W-1){1'b0}}};
    localparam logic signed [sdlg_pkg::RES_W-1:0]  S64_MAX = {1'b0, {(sdlg_pkg::RES_W-1){1'b1}}};
    localparam logic signed [sdlg_pkg::RES_W-1:0]  S64_MIN = {1'b1, {(sdlg_pkg::RES_W-1){1'b0}}};

    function automatic logic signed [sdlg_pkg::DATA_W-1:0] sat32(
        input logic signed [sdlg_pkg::ACC_W-1:0] v);
        logic [sdlg_pkg::ACC_W-sdlg_pkg::DATA_W:0] hi_bits;
        hi_bits = v[sdlg_pkg::ACC_W-1:sdlg_pkg::DATA_W-1];
        if (hi_bits == '0 || hi_bits == '1)
            sat32 = v[sdlg_pkg::DATA_W-1:0];
        else if (v[sdlg_pkg::ACC_W-1])
            sat32 = S32_MIN;
        else
            sat32 = S32_MAX;
    endfunction

    function automatic logic signed [sdlg_pkg::RES_W-1:0] sat64(
        input logic signed [sdlg_pkg::ACC_W-1:0] v);
        logic [sdlg_pkg::ACC_W-sdlg_pkg::RES_W:0] hi_bits;
        hi_bits = v[sdlg_pkg::ACC_W-1:sdlg_pkg::RES_W-1];
        if (hi_bits == '0 || hi_bits == '1)
            sat64 = v[sdlg_pkg::RES_W-1:0];
        else if (v[sdlg_pkg::ACC_W-1])
            sat64 = S64_MIN;
        else
            sat64 = S64_MAX;
    endfunction

    sdlg_pkg::mac_issue_t issue_d1_reg;
    sdlg_pkg::mac_issue_t issue_d2_reg;

    logic signed [sdlg_pkg::DATA_W-1:0] op_a;
    logic signed [sdlg_pkg::DATA_W-1:0] op_b;
    logic signed [sdlg_pkg::RES_W-1:0]  prod_next;
    logic signed [sdlg_pkg::RES_W-1:0]  prod_reg;
    logic signed [sdlg_pkg::ACC_W-1:0]  row_acc_reg;
    logic signed [sdlg_pkg::ACC_W-1:0]  loss_acc_reg;
    logic signed [sdlg_pkg::SUM_W-1:0]  sum_reg;
    logic signed [sdlg_pkg::DATA_W-1:0] gprime_reg;
    logic signed [sdlg_pkg::DATA_W-1:0] grad_reg;
    logic signed [sdlg_pkg::RES_W-1:0]  loss_res_reg;
    logic signed [sdlg_pkg::ACC_W-1:0]  gp_wide;
    logic signed [sdlg_pkg::ACC_W-1:0]  g_wide;
    logic signed [sdlg_pkg::ACC_W-1:0]  loss_wide;

    // stage 1: operands from memory (or the held g' for the loss term)
    assign op_a      = issue_d1_reg.loss ? gprime_reg : mat_rdata;
    assign op_b      = issue_d1_reg.zero_b ? '0 : alpha_rdata;
    assign prod_next = op_a * op_b;

    // Q32.32 sum to Q16.16; the -1 bias is exact after the shift
    assign gp_wide   = row_acc_reg >>> 16;
    assign g_wide    = gp_wide - GRAD_BIAS;
    assign loss_wide = (loss_acc_reg >>> 1) - (sdlg_pkg::ACC_W'(sum_reg) <<< 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_d1_reg <= '0;
            issue_d2_reg <= '0;
        end
        else
        begin
            issue_d1_reg <= ctrl.issue;
            issue_d2_reg <= issue_d1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;

        if (ctrl.row_clear)
            row_acc_reg <= '0;
        else if (issue_d2_reg.valid && !issue_d2_reg.loss)
            row_acc_reg <= row_acc_reg + sdlg_pkg::ACC_W'(prod_reg);

        if (ctrl.start)
            loss_acc_reg <= '0;
        else if (issue_d2_reg.valid && issue_d2_reg.loss)
            loss_acc_reg <= loss_acc_reg + sdlg_pkg::ACC_W'(prod_reg);

        // alpha sum rides along with the first column pass
        if (ctrl.start)
            sum_reg <= '0;
        else if (issue_d1_reg.valid && !issue_d1_reg.loss && issue_d1_reg.first_row)
            sum_reg <= sum_reg + sdlg_pkg::SUM_W'(alpha_rdata);

        if (ctrl.grad_latch)
        begin
            gprime_reg <= sat32(gp_wide);
            grad_reg   <= sat32(g_wide);
        end

        if (ctrl.loss_latch)
            loss_res_reg <= sat64(loss_wide);
    end

    assign grad = grad_reg;
    assign loss = loss_res_reg;

endmodule

// ===== design/sdlg_seq.sv =====
// ----------------------------------------------------------------------------
// SVM dual gradient sequencer
// Walks columns and rows, drives memory reads and the shared MAC, emits results.
// ----------------------------------------------------------------------------
module sdlg_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [sdlg_pkg::CNT_W-1:0]       active_size,
    input  logic [sdlg_pkg::CNT_W-1:0]       alpha_count,
    input  logic                             out_free,
    output logic                             busy,
    output logic [sdlg_pkg::IDX_W-1:0]       alpha_raddr,
    output logic [sdlg_pkg::MAT_AW-1:0]      mat_raddr,
    output sdlg_pkg::mac_ctrl_t              ctrl,
    output sdlg_pkg::emit_t                  emit
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAC    = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_SAT    = 3'd3;
    localparam logic [2:0] S_GRAD   = 3'd4;
    localparam logic [2:0] S_LDRAIN = 3'd5;
    localparam logic [2:0] S_LFIN   = 3'd6;
    localparam logic [2:0] S_LOSS   = 3'd7;

    logic [2:0]                 state_reg, state_next;
    logic [sdlg_pkg::CNT_W-1:0] i_reg, i_next;
    logic [sdlg_pkg::CNT_W-1:0] j_reg, j_next;
    logic [sdlg_pkg::CNT_W-1:0] n_reg, n_next;
    logic [sdlg_pkg::CNT_W-1:0] m_reg, m_next;
    logic                       wait_reg, wait_next;
    logic [sdlg_pkg::CNT_W-1:0] n_start;
    logic [sdlg_pkg::CNT_W-1:0] m_start;
    logic                       i_last;
    logic                       j_last;

    assign n_start = (active_size > sdlg_pkg::SIZE_LIMIT) ? sdlg_pkg::SIZE_LIMIT : active_size;
    assign m_start = (alpha_count < n_start) ? alpha_count : n_start;
    assign i_last  = (sdlg_pkg::CNT_W'(i_reg + 1'b1) == n_reg);
    assign j_last  = (sdlg_pkg::CNT_W'(j_reg + 1'b1) == m_reg);
    assign busy    = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        wait_next   = wait_reg;
        ctrl        = '0;
        emit        = '0;
        emit.index  = i_reg;
        alpha_raddr = j_reg[sdlg_pkg::IDX_W-1:0];
        mat_raddr   = sdlg_pkg::mat_addr(j_reg, i_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.start     = 1'b1;
                    ctrl.row_clear = 1'b1;
                    n_next         = n_start;
                    m_next         = m_start;
                    i_next         = '0;
                    j_next         = '0;
                    wait_next      = 1'b0;
                    if (n_start == '0)
                        state_next = S_LDRAIN;
                    else if (m_start == '0)
                        state_next = S_DRAIN;
                    else
                        state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                ctrl.issue.valid     = 1'b1;
                ctrl.issue.first_row = (i_reg == '0);
                if (j_last)
                begin
                    state_next = S_DRAIN;
                    wait_next  = 1'b0;
                end
                else
                begin
                    j_next = sdlg_pkg::CNT_W'(j_reg + 1'b1);
                end
            end
            S_DRAIN:
            begin
                if (wait_reg)
                    state_next = S_SAT;
                else
                    wait_next = 1'b1;
            end
            S_SAT:
            begin
                ctrl.grad_latch   = 1'b1;
                ctrl.issue.valid  = 1'b1;
                ctrl.issue.loss   = 1'b1;
                ctrl.issue.zero_b = (i_reg >= m_reg);
                alpha_raddr       = i_reg[sdlg_pkg::IDX_W-1:0];
                state_next        = S_GRAD;
            end
            S_GRAD:
            begin
                if (out_free)
                begin
                    emit.load_grad = 1'b1;
                    j_next         = '0;
                    wait_next      = 1'b0;
                    if (i_last)
                    begin
                        state_next = S_LDRAIN;
                    end
                    else
                    begin
                        i_next         = sdlg_pkg::CNT_W'(i_reg + 1'b1);
                        ctrl.row_clear = 1'b1;
                        state_next     = (m_reg == '0) ? S_DRAIN : S_MAC;
                    end
                end
            end
            S_LDRAIN:
            begin
                if (wait_reg)
                    state_next = S_LFIN;
                else
                    wait_next = 1'b1;
            end
            S_LFIN:
            begin
                ctrl.loss_latch = 1'b1;
                state_next      = S_LOSS;
            end
            S_LOSS:
            begin
                if (out_free)
                begin
                    emit.load_loss = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            m_reg     <= '0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

// ===== design/svm_dual_loss_gradient_unit.sv =====
// ----------------------------------------------------------------------------
// SVM dual objective gradient unit
// Matrix store plus one shared MAC that emits the dual gradient and loss.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall): operation 0 writes matrix entry
//   A[row][column] = value (Q16.16); operation 1 appends the next alpha.
//   An alpha with last set starts an evaluation over n = min(active_size,
//   MAX_SIZE) columns using the m = min(alphas this run, n) alphas given.
//   Writes and alphas without last are taken only while no evaluation runs.
//   Result channel (res_valid / res_stall): n gradient transfers (kind 0,
//   Q16.16 sign extended) in index order, then one loss transfer (kind 1,
//   Q32.32, final_res set).
//   A single 32x32 multiplier does all products, one per cycle during a
//   column pass; each gradient takes m products, a pipeline drain and
//   saturation. item_stall stays high for the whole evaluation.
//   A stalled result holds in the output register and the sequencer waits.
//   Config port (cfg_valid / cfg_ready): writes active_size; always ready,
//   write only while idle.
//   Reset: active_size returns to 32, the alpha count clears; the memories
//   keep their contents and hold nothing defined until written.
// ----------------------------------------------------------------------------
module svm_dual_loss_gradient_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sdlg_pkg::CNT_W-1:0]         cfg_data,
    // item channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               operation,
    input  logic [sdlg_pkg::CNT_W-1:0]         row,
    input  logic [sdlg_pkg::CNT_W-1:0]         column,
    input  logic signed [sdlg_pkg::DATA_W-1:0] value,
    input  logic                               last,
    // result channel
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [sdlg_pkg::CNT_W-1:0]         index,
    output logic                               kind,
    output logic signed [sdlg_pkg::RES_W-1:0]  result_value,
    output logic                               final_res
);

    logic                               item_accept;
    logic                               busy;
    logic                               start;
    logic                               out_free;
    logic                               mat_we;
    logic                               alpha_we;
    logic                               alpha_take;
    logic [sdlg_pkg::CNT_W-1:0]         active_size_reg;
    logic [sdlg_pkg::CNT_W-1:0]         alpha_count_reg, alpha_count_next;
    logic [sdlg_pkg::CNT_W-1:0]         alpha_count_inc;
    logic [sdlg_pkg::IDX_W-1:0]         alpha_raddr;
    logic [sdlg_pkg::MAT_AW-1:0]        mat_raddr;
    logic signed [sdlg_pkg::DATA_W-1:0] mat_rdata;
    logic signed [sdlg_pkg::DATA_W-1:0] alpha_rdata;
    logic signed [sdlg_pkg::DATA_W-1:0] grad;
    logic signed [sdlg_pkg::RES_W-1:0]  loss;
    sdlg_pkg::mac_ctrl_t                ctrl;
    sdlg_pkg::emit_t                    emit;

    logic                               res_valid_reg;
    logic [sdlg_pkg::CNT_W-1:0]         index_reg;
    logic                               kind_reg;
    logic signed [sdlg_pkg::RES_W-1:0]  value_reg;
    logic                               final_reg;

    // Input side: no item is taken while an evaluation runs.
    assign item_stall  = busy;
    assign item_accept = item_valid && !item_stall;
    assign alpha_take  = item_accept && (operation == sdlg_pkg::OP_ALPHA);
    assign start       = alpha_take && last;

    // Drop matrix writes outside the built size.
    assign mat_we   = item_accept && (operation == sdlg_pkg::OP_WRITE)
                      && (row < sdlg_pkg::SIZE_LIMIT) && (column < sdlg_pkg::SIZE_LIMIT);
    // Alphas past the built size are counted but not stored.
    assign alpha_we = alpha_take && (alpha_count_reg < sdlg_pkg::SIZE_LIMIT);

    // Saturate the alpha count at its top code.
    assign alpha_count_inc = (alpha_count_reg < sdlg_pkg::CNT_MAX)
                             ? sdlg_pkg::CNT_W'(alpha_count_reg + 1'b1) : alpha_count_reg;

    always_comb
    begin
        alpha_count_next = alpha_count_reg;
        if (emit.load_loss)
            alpha_count_next = '0;
        else if (alpha_take)
            alpha_count_next = alpha_count_inc;
    end

    // Configuration: a single register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= sdlg_pkg::ACTIVE_RESET;
            alpha_count_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                active_size_reg <= cfg_data;
            alpha_count_reg <= alpha_count_next;
        end
    end

    sdlg_store u_store (
        .clk         (clk),
        .mat_we      (mat_we),
        .mat_waddr   (sdlg_pkg::mat_addr(row, column)),
        .mat_wdata   (value),
        .mat_raddr   (mat_raddr),
        .mat_rdata   (mat_rdata),
        .alpha_we    (alpha_we),
        .alpha_waddr (alpha_count_reg[sdlg_pkg::IDX_W-1:0]),
        .alpha_wdata (value),
        .alpha_raddr (alpha_raddr),
        .alpha_rdata (alpha_rdata)
    );

    // The sequencer sees the count including the alpha that carries last.
    sdlg_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .active_size (active_size_reg),
        .alpha_count (alpha_count_inc),
        .out_free    (out_free),
        .busy        (busy),
        .alpha_raddr (alpha_raddr),
        .mat_raddr   (mat_raddr),
        .ctrl        (ctrl),
        .emit        (emit)
    );

    sdlg_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .mat_rdata   (mat_rdata),
        .alpha_rdata (alpha_rdata),
        .grad        (grad),
        .loss        (loss)
    );

    // Output register: load when empty or when the held transfer leaves.
    assign out_free = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (emit.load_grad || emit.load_loss)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit.load_grad)
        begin
            index_reg <= emit.index;
            kind_reg  <= sdlg_pkg::KIND_GRAD;
            value_reg <= sdlg_pkg::RES_W'(grad);
            final_reg <= 1'b0;
        end
        else if (emit.load_loss)
        begin
            index_reg <= '0;
            kind_reg  <= sdlg_pkg::KIND_LOSS;
            value_reg <= loss;
            final_reg <= 1'b1;
        end
    end

    assign res_valid    = res_valid_reg;
    assign index        = index_reg;
    assign kind         = kind_reg;
    assign result_value = value_reg;
    assign final_res    = final_reg;

endmodule

// ===== design/sdlg_checker.sv =====
// ----------------------------------------------------------------------------
// SVM dual gradient port checker
// Port-level properties of the unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "svm_dual_loss_gradient_unit_macros.svh"

module sdlg_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [sdlg_pkg::CNT_W-1:0]         cfg_data,
    input logic                               item_valid,
    input logic                               item_stall,
    input logic                               operation,
    input logic [sdlg_pkg::CNT_W-1:0]         row,
    input logic [sdlg_pkg::CNT_W-1:0]         column,
    input logic signed [sdlg_pkg::DATA_W-1:0] value,
    input logic                               last,
    input logic                               res_valid,
    input logic                               res_stall,
    input logic [sdlg_pkg::CNT_W-1:0]         index,
    input logic                               kind,
    input logic signed [sdlg_pkg::RES_W-1:0]  result_value,
    input logic                               final_res
);

    // hold a stalled result transfer
    `SDLG_ASSERT(a_res_hold, (res_valid && res_stall) |=> (res_valid && $stable(result_value) && $stable(kind) && $stable(index) && $stable(final_res)), "stalled result changed")

    // a closing alpha must block further items next cycle
    `SDLG_ASSERT(a_last_blocks, (item_valid && !item_stall && operation == sdlg_pkg::OP_ALPHA && last) |=> item_stall, "item taken during evaluation")

    // only the loss closes a run, and it carries index zero
    `SDLG_ASSERT(a_final_loss, res_valid |-> ((final_res == (kind == sdlg_pkg::KIND_LOSS)) && (!final_res || index == '0)), "final flag and kind disagree")

    // gradients only appear while an evaluation is open
    `SDLG_ASSERT_ALWAYS(a_grad_busy, (res_valid && kind == sdlg_pkg::KIND_GRAD) |-> item_stall, "gradient outside evaluation")

    // a gradient is a sign-extended 32-bit value
    `SDLG_ASSERT(a_grad_range, (res_valid && kind == sdlg_pkg::KIND_GRAD) |-> (result_value[63:31] == '0 || result_value[63:31] == '1), "gradient not sign extended")

endmodule

bind svm_dual_loss_gradient_unit sdlg_checker u_sdlg_checker (.*);

// ===== bench/sdlg_bench_pkg.sv =====
// ----------------------------------------------------------------------------
// SVM dual gradient bench package
// Holds a running model of the matrix store and alpha run. Each accepted
// item is noted, and the gradient and loss transfers it should cause are
// queued. Each result transfer is then checked against the oldest entry.
// ----------------------------------------------------------------------------
package sdlg_bench_pkg;

    import sdlg_pkg::*;

    typedef struct {
        logic [CNT_W-1:0]         index;
        logic                     kind;
        logic signed [RES_W-1:0]  value;
        logic                     last_of_run;
    } grad_result_t;

    class dual_objective_tracker;

        logic signed [DATA_W-1:0] coeff [MAX_SIZE][MAX_SIZE];
        bit                       entry_set [MAX_SIZE][MAX_SIZE];
        logic signed [DATA_W-1:0] alphas [MAX_SIZE];
        int unsigned              alpha_seen;
        logic [CNT_W-1:0]         size_reg;
        grad_result_t             awaited_results [$];
        int unsigned              mismatches;

        function new();
            size_reg   = ACTIVE_RESET;
            alpha_seen = 0;
            mismatches = 0;
        endfunction

        function void set_size(input logic [CNT_W-1:0] sz);
            size_reg = sz;
        endfunction

        // sizes above the built size act as the built size
        function int columns_in_use();
            return (int'(size_reg) < MAX_SIZE) ? int'(size_reg) : MAX_SIZE;
        endfunction

        function logic signed [RES_W-1:0] saturate(input logic signed [127:0] x,
                                                   input int unsigned bits);
            logic signed [127:0] hi;
            logic signed [127:0] lo;
            hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
            lo = -hi - 128'sd1;
            if (x > hi)
                return RES_W'(hi);
            if (x < lo)
                return RES_W'(lo);
            return RES_W'(x);
        endfunction

        function void evaluate();
            int                  n;
            int                  m;
            logic signed [127:0] acc;
            logic signed [127:0] loss_acc;
            logic signed [127:0] run_sum;
            logic signed [127:0] a_w;
            logic signed [127:0] c_w;
            logic signed [127:0] g_prime;
            grad_result_t        res;
            n = columns_in_use();
            m = (int'(alpha_seen) < n) ? int'(alpha_seen) : n;
            run_sum = '0;
            for (int j = 0; j < m; j++)
                run_sum += alphas[j];
            loss_acc = '0;
            for (int i = 0; i < n; i++) begin
                acc = '0;
                for (int j = 0; j < m; j++) begin
                    a_w = alphas[j];
                    c_w = coeff[j][i];
                    acc += a_w * c_w;
                end
                g_prime = saturate(acc >>> 16, 32);
                res.index       = CNT_W'(i);
                res.kind        = KIND_GRAD;
                res.value       = saturate((acc - (128'sd1 <<< 32)) >>> 16, 32);
                res.last_of_run = 1'b0;
                awaited_results.push_back(res);
                if (i < m)
                    a_w = alphas[i];
                else
                    a_w = '0;
                loss_acc += g_prime * a_w;
            end
            res.index       = '0;
            res.kind        = KIND_LOSS;
            res.value       = saturate((loss_acc >>> 1) - (run_sum <<< 16), 64);
            res.last_of_run = 1'b1;
            awaited_results.push_back(res);
            alpha_seen = 0;
        endfunction

        function void take_item(input logic op, input logic [CNT_W-1:0] r,
                                input logic [CNT_W-1:0] c,
                                input logic signed [DATA_W-1:0] v, input logic lst);
            if (op == OP_WRITE) begin
                // drop writes outside the store; ignore last on a write
                if (r < MAX_SIZE && c < MAX_SIZE) begin
                    coeff[r][c]     = v;
                    entry_set[r][c] = 1'b1;
                end
                return;
            end
            if (alpha_seen < MAX_SIZE)
                alphas[alpha_seen] = v;
            if (alpha_seen < CNT_MAX)
                alpha_seen++;
            if (lst)
                evaluate();
        endfunction

        function void check_result(input logic [CNT_W-1:0] idx, input logic knd,
                                   input logic signed [RES_W-1:0] val, input logic fin);
            grad_result_t want;
            if (awaited_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result transfer: index=%0d kind=%0d value=%0d final_res=%0b",
                             idx, knd, val, fin);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (idx !== want.index || knd !== want.kind || val !== want.value
                    || fin !== want.last_of_run) begin
                if (mismatches < 10)
                    $display("result transfer differs: expected index=%0d kind=%0d value=%0d %s%0b",
                             want.index, want.kind, want.value, "final_res=",
                             want.last_of_run,
                             "\n    got index=%0d kind=%0d value=%0d final_res=%0b",
                             idx, knd, val, fin);
                mismatches++;
            end
        endfunction

        function bit all_clear();
            return mismatches == 0 && awaited_results.size() == 0;
        endfunction

    endclass

endpackage

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// SVM dual gradient unit testbench
// Loads matrix entries and streams alpha runs into the unit, then checks
// every gradient and loss transfer against a running model. A short directed
// part hits the value extremes, a write with last set, ignored writes, short
// and long alpha runs and a zero size. Random phases follow under several
// idling patterns and active sizes, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import sdlg_pkg::*;
    import sdlg_bench_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int          RESET_CYCLES  = 12;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          PHASE_ITEMS   = 40;
    localparam int unsigned RANDOM_ITEMS  = 380;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned RUN_LIMIT_NS  = 100_000_000;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         cfg_data     = '0;
    logic                     item_valid   = 1'b0;
    logic                     item_stall;
    logic                     operation    = OP_WRITE;
    logic [CNT_W-1:0]         row          = '0;
    logic [CNT_W-1:0]         column       = '0;
    logic signed [DATA_W-1:0] value        = '0;
    logic                     last         = 1'b0;
    logic                     res_valid;
    logic                     res_stall    = 1'b0;
    logic [CNT_W-1:0]         index;
    logic                     kind;
    logic signed [RES_W-1:0]  result_value;
    logic                     final_res;

    // idling knobs, in percent per cycle
    int unsigned              sender_gap_pct = 0;
    int unsigned              stall_pct      = 0;
    logic                     hold_results   = 1'b0;
    int unsigned              items_sent     = 0;

    dual_objective_tracker    tracker;

    svm_dual_loss_gradient_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .row          (row),
        .column       (column),
        .value        (value),
        .last         (last),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .index        (index),
        .kind         (kind),
        .result_value (result_value),
        .final_res    (final_res)
    );

    always #(CLK_HALF) clk = ~clk;

    // Result side: check each transfer at the edge that completes it, then
    // pick the stall for the next cycle. A hold-off keeps stall high throughout.
    always @(posedge clk)
    begin
        if (rst_n && res_valid === 1'b1 && res_stall == 1'b0)
            tracker.check_result(index, kind, result_value, final_res);
        res_stall <= hold_results || ($urandom_range(99) < stall_pct);
    end

    // Hard stop in case the unit hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("svm_dual_loss_gradient_unit: mismatch");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return DATA_W'($urandom);
            3:       return '0;
            // small Q16.16 values, roughly -2.0 .. 2.0
            default: return DATA_W'($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // Offer one item and hold it until the unit takes the transfer. An idle
    // gap, if drawn, comes before the item so valid is never dropped and
    // raised in the same step.
    task automatic send_item(input logic op, input logic [CNT_W-1:0] r,
                             input logic [CNT_W-1:0] c,
                             input logic signed [DATA_W-1:0] v, input logic lst);
        if ($urandom_range(99) < sender_gap_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_gap_pct);
        end
        item_valid <= 1'b1;
        operation  <= op;
        row        <= r;
        column     <= c;
        value      <= v;
        last       <= lst;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        tracker.take_item(op, r, c, v, lst);
        items_sent++;
    endtask

    task automatic write_size(input logic [CNT_W-1:0] sz);
        cfg_valid <= 1'b1;
        cfg_data  <= sz;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        tracker.set_size(sz);
    endtask

    // Drop valid, wait for every queued result, then give the unit time to
    // finish any trailing write before touching the register.
    task automatic settle();
        item_valid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0:
            begin
                sender_gap_pct <= 0;
                stall_pct      <= 0;
            end
            1:
            begin
                sender_gap_pct <= 72;
                stall_pct      <= 0;
            end
            2:
            begin
                sender_gap_pct <= 0;
                stall_pct      <= 72;
            end
            default:
            begin
                sender_gap_pct <= 22;
                stall_pct      <= 22;
            end
        endcase
    endtask

    task automatic hold_results_for(input int unsigned cycles);
        hold_results <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_results <= 1'b0;
    endtask

    task automatic random_write(input bit in_range);
        logic [CNT_W-1:0] r;
        logic [CNT_W-1:0] c;
        if (in_range)
        begin
            r = CNT_W'($urandom_range(MAX_SIZE - 1));
            c = CNT_W'($urandom_range(MAX_SIZE - 1));
        end
        else
        begin
            r = CNT_W'($urandom);
            c = CNT_W'($urandom);
            // push the row past the store if both landed inside it
            if (r < MAX_SIZE && c < MAX_SIZE)
                r[CNT_W-1] = 1'b1;
        end
        send_item(OP_WRITE, r, c, pick_value(), 1'($urandom_range(1)));
    endtask

    // One well-formed alpha run: first write every entry the evaluation will
    // read that is still unset, then stream the alphas with last on the end.
    task automatic alpha_run(input int unsigned len);
        int n;
        int used;
        n    = tracker.columns_in_use();
        used = (int'(len) < n) ? int'(len) : n;
        for (int j = 0; j < used; j++)
            for (int i = 0; i < n; i++)
                if (!tracker.entry_set[j][i])
                    send_item(OP_WRITE, CNT_W'(j), CNT_W'(i), pick_value(),
                              1'($urandom_range(1)));
        for (int k = 0; k < int'(len); k++)
        begin
            if ($urandom_range(9) == 0)
                random_write(1'b1);
            send_item(OP_ALPHA, CNT_W'($urandom), CNT_W'($urandom), pick_value(),
                      k == int'(len) - 1);
        end
    endtask

    task automatic random_action();
        int unsigned pick;
        int unsigned n;
        int unsigned len;
        pick = $urandom_range(9);
        n    = tracker.columns_in_use();
        if (pick < 2)
        begin
            random_write(1'b1);
        end
        else if (pick == 2)
        begin
            random_write(1'b0);
        end
        else
        begin
            // keep runs short on wide sizes so the matrix fill stays small
            if (n >= 16 || n == 0)
                len = $urandom_range(1, 3);
            else if (pick == 3 && n <= 8 && $urandom_range(3) == 0)
                len = $urandom_range(64, 70);
            else if (pick <= 5)
                len = n + $urandom_range(1, 4);
            else if (pick <= 7 && n > 1)
                len = $urandom_range(1, n - 1);
            else
                len = n;
            alpha_run(len);
        end
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned random_start;
        int unsigned phase_start;
        logic [CNT_W-1:0] sz;

        tracker = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: a 2x2 matrix with extreme entries.
        write_size(CNT_W'(2));
        send_item(OP_WRITE, '0, '0, 32'sh7FFF_FFFF, 1'b1);   // last on a write is ignored
        send_item(OP_WRITE, '0, CNT_W'(1), 32'sh8000_0000, 1'b0);
        send_item(OP_WRITE, CNT_W'(1), '0, -32'sd1, 1'b0);
        send_item(OP_WRITE, CNT_W'(1), CNT_W'(1), 32'sh7FFF_FFFF, 1'b0);
        send_item(OP_WRITE, CNT_W'(63), '0, 32'sd123, 1'b1);  // row past the store
        send_item(OP_WRITE, '0, CNT_W'(63), -32'sd5, 1'b0);   // column past the store
        // saturate gradients and loss both ways
        send_item(OP_ALPHA, '0, '0, 32'sh7FFF_FFFF, 1'b0);
        send_item(OP_ALPHA, CNT_W'(63), CNT_W'(63), 32'sh7FFF_FFFF, 1'b1);
        send_item(OP_ALPHA, '0, '0, 32'sh8000_0000, 1'b0);
        send_item(OP_ALPHA, '0, '0, 32'sh8000_0000, 1'b1);
        // short run: the missing alpha counts as zero
        send_item(OP_ALPHA, '0, '0, 32'sh0001_0000, 1'b1);
        // long run: alphas past the active size are unused
        send_item(OP_ALPHA, '0, '0, 32'sh0000_8000, 1'b0);
        send_item(OP_ALPHA, '0, '0, -32'sh0001_8000, 1'b0);
        send_item(OP_ALPHA, '0, '0, 32'sh0003_0000, 1'b0);
        send_item(OP_ALPHA, '0, '0, 32'sh7FFF_FFFF, 1'b1);
        settle();
        // zero size: loss transfer only
        write_size('0);
        send_item(OP_ALPHA, '0, '0, 32'sh0002_0000, 1'b1);
        settle();

        // Random phases, each with its own size and idling pattern.
        random_start = items_sent;
        phase        = 0;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            case (phase)
                0: sz = CNT_W'(1);
                1: sz = CNT_W'(63);
                2: sz = CNT_W'(5);
                3: sz = CNT_W'(33);
                4: sz = CNT_W'(32);
                5: sz = CNT_W'(0);
                6: sz = CNT_W'(31);
                default: sz = ($urandom_range(7) == 0) ? CNT_W'(31)
                                                       : CNT_W'($urandom_range(1, 8));
            endcase
            set_idling(phase % 4);
            write_size(sz);
            phase_start = items_sent;
            if (phase == 0)
            begin
                // hold results back while items keep coming, so the unit
                // backs up and stalls the item channel
                fork
                    hold_results_for(HOLD_CYCLES);
                join_none
                alpha_run(3);
            end
            if (phase == 2)
                alpha_run(66);     // drive the alpha count into saturation
            while (items_sent - phase_start < PHASE_ITEMS)
                random_action();
            settle();
            phase++;
        end

        if (tracker.all_clear())
            $display("svm_dual_loss_gradient_unit: match");
        else
            $display("svm_dual_loss_gradient_unit: mismatch");
        $finish;
    end

endmodule
